[design/cmbd_pkg.sv]
`default_nettype none
package cmbd_pkg;

   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_DILATE = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   localparam logic REG_IMAGE_SIDE = 1'b0;
   localparam logic REG_PASS_COUNT = 1'b1;

   localparam logic [7:0] SIDE_RESET = 8'd128;
   localparam logic [3:0] PASS_RESET = 4'd4;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [6:0]  texel_x;
      logic [6:0]  texel_y;
      logic [15:0] red_in;
      logic [15:0] green_in;
      logic [15:0] blue_in;
      logic        covered_in;
   } req_type;

   typedef struct packed {
      logic        reply_kind;
      logic [15:0] red_out;
      logic [15:0] green_out;
      logic [15:0] blue_out;
      logic        covered_out;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_REPLY,
      ST_PASS_START,
      ST_CENTER_READ,
      ST_CENTER_CHECK,
      ST_NBR_READ,
      ST_NBR_ACC,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_WRITE_BACK,
      ST_PASS_END,
      ST_DONE_REPLY
   } state_type;

   typedef struct packed {
      logic host_accept;
      logic load_pass;
      logic pass_end;
      logic texel_reset;
      logic texel_next;
      logic center_issue;
      logic write_copy_rd;
      logic write_copy_hold;
      logic acc_clear;
      logic nbr_issue;
      logic acc_en;
      logic div_load;
      logic div_step;
      logic write_mean;
      logic reply_read;
      logic reply_done;
   } ctl_type;

   typedef struct packed {
      logic req_in_range;
      logic passes_zero;
      logic side_zero;
      logic last_texel;
      logic center_covered;
      logic nbr_last;
      logic count_zero;
      logic div_done;
   } status_type;

endpackage
`default_nettype wire

[design/coverage_masked_box_dilation_unit.sv]
`default_nettype none
// masked 3x3 box dilation over a square lightmap store
// request: start with req_data, taken when start is high and busy is low
//   write texel: written at the accepting edge, busy stays low, out-of-range ignored
//   read texel: rsp_valid in the cycle after the accepting edge (registered read),
//     busy high while the reply is shown, so no new request is taken until it is out
//   dilate: runs pass_count passes, then one rsp_valid with reply_kind done
// per pass: a covered texel is copied; an uncovered texel reads its nine neighbours
//   one at a time through the one memory read port, then is copied if none is covered,
//   else takes the mean of the covered ones from a bit-serial divider over the channel sums
// rsp_valid lasts one cycle; the receiver cannot hold it off
// csr port: csr_we, csr_index 0 image_side, 1 pass_count; idle writes only
// reset: synchronous, busy held high while asserted; restores image_side 128,
//   pass_count 4, bank a current; texel memory is not cleared and holds
//   nothing until written
module coverage_masked_box_dilation_unit
   import cmbd_pkg::*;
#(
   parameter int MAX_SIDE     = 128,
   parameter int CHANNEL_BITS = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  var  req_type    req_data,
   output logic            rsp_valid,
   output var  rsp_type    rsp_data,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata
);

   ctl_type    ctl;
   status_type status;

   // sequencer: one request at a time
   cmbd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .cmd    (req_data.cmd),
      .status (status),
      .ctl    (ctl),
      .busy   (busy)
   );

   // double-buffered texel banks, neighbour gather and divider
   cmbd_datapath #(
      .MAX_SIDE     (MAX_SIDE),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ctl       (ctl),
      .status    (status),
      .rsp_data  (rsp_data)
   );

   // strobe for read data or dilation finished
   assign rsp_valid = ctl.reply_read || ctl.reply_done;

endmodule
`default_nettype wire

[design/cmbd_ctrl.sv]
`default_nettype none
module cmbd_ctrl
   import cmbd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [1:0] cmd,
   input  var  status_type status,
   output var  ctl_type    ctl,
   output logic            busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (cmd == CMD_DILATE) begin
                  state_in = ST_PASS_START;
               end else if (cmd == CMD_READ && status.req_in_range) begin
                  state_in = ST_READ_REPLY;
               end
            end
         end
         ST_READ_REPLY: state_in = ST_IDLE;
         ST_PASS_START: begin
            if (status.passes_zero) begin
               state_in = ST_DONE_REPLY;
            end else if (status.side_zero) begin
               state_in = ST_PASS_END;
            end else begin
               state_in = ST_CENTER_READ;
            end
         end
         ST_CENTER_READ: state_in = ST_CENTER_CHECK;
         ST_CENTER_CHECK: begin
            if (status.center_covered) begin
               state_in = status.last_texel ? ST_PASS_END : ST_CENTER_READ;
            end else begin
               state_in = ST_NBR_READ;
            end
         end
         ST_NBR_READ: state_in = ST_NBR_ACC;
         ST_NBR_ACC: state_in = status.nbr_last ? ST_DIV_LOAD : ST_NBR_READ;
         ST_DIV_LOAD: begin
            if (status.count_zero) begin
               state_in = status.last_texel ? ST_PASS_END : ST_CENTER_READ;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: state_in = status.div_done ? ST_WRITE_BACK : ST_DIVIDE;
         ST_WRITE_BACK: state_in = status.last_texel ? ST_PASS_END : ST_CENTER_READ;
         ST_PASS_END: state_in = ST_PASS_START;
         ST_DONE_REPLY: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            // no request is taken while reset is held
            busy = reset;
            ctl.host_accept = start && !reset;
            ctl.load_pass   = start && !reset && (cmd == CMD_DILATE);
            ctl.texel_reset = 1'b1;
         end
         ST_READ_REPLY: ctl.reply_read = 1'b1;
         ST_PASS_START: ctl.texel_reset = 1'b1;
         ST_CENTER_READ: ctl.center_issue = 1'b1;
         ST_CENTER_CHECK: begin
            ctl.acc_clear = 1'b1;
            if (status.center_covered) begin
               ctl.write_copy_rd = 1'b1;
               ctl.texel_next    = 1'b1;
            end
         end
         ST_NBR_READ: ctl.nbr_issue = 1'b1;
         ST_NBR_ACC: ctl.acc_en = 1'b1;
         ST_DIV_LOAD: begin
            ctl.div_load = 1'b1;
            if (status.count_zero) begin
               ctl.write_copy_hold = 1'b1;
               ctl.texel_next      = 1'b1;
            end
         end
         ST_DIVIDE: ctl.div_step = !status.div_done;
         ST_WRITE_BACK: begin
            ctl.write_mean = 1'b1;
            ctl.texel_next = 1'b1;
         end
         ST_PASS_END: ctl.pass_end = 1'b1;
         ST_DONE_REPLY: ctl.reply_done = 1'b1;
         default: ctl = '0;
      endcase
   end

endmodule
`default_nettype wire

[design/cmbd_datapath.sv]
`default_nettype none
module cmbd_datapath
   import cmbd_pkg::*;
#(
   parameter int MAX_SIDE     = 128,
   parameter int CHANNEL_BITS = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  var  req_type    req_data,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata,
   input  var  ctl_type    ctl,
   output var  status_type status,
   output var  rsp_type    rsp_data
);

   localparam int CELLS = MAX_SIDE * MAX_SIDE;
   localparam int AW    = $clog2(CELLS);
   localparam int SW    = $clog2(MAX_SIDE + 1);
   localparam int CB    = CHANNEL_BITS;
   localparam int WW    = 3 * CB + 1;
   localparam int SUMW  = CB + 3;
   localparam int DCW   = $clog2(SUMW + 1);

   // word layout: {covered, blue, green, red}
   logic [WW-1:0] mem_a [CELLS];
   logic [WW-1:0] mem_b [CELLS];
   logic [WW-1:0] rd_a_ff, rd_b_ff, rd_word, hold_ff, wdata;
   logic [AW-1:0] raddr, waddr;
   logic          we_a, we_b;

   logic [7:0] side_reg_ff;
   logic [3:0] pass_reg_ff, passes_ff;
   logic       bank_ff;
   logic [SW-1:0] side_eff, x_ff, y_ff;
   logic [1:0] kx_ff, ky_ff;
   logic [SW:0] nx, ny;
   logic        nbr_ok, nbr_ok_ff;
   logic [AW-1:0] center_addr, nbr_addr, req_addr;

   logic [SUMW-1:0] acc_ff [3];
   logic [3:0]      count_ff;
   logic [SUMW-1:0] quo_ff [3];
   logic [3:0]      rem_ff [3];
   logic [DCW-1:0]  div_cnt_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         side_reg_ff <= SIDE_RESET;
         pass_reg_ff <= PASS_RESET;
      end else if (csr_we) begin
         if (csr_index == REG_IMAGE_SIDE) begin
            side_reg_ff <= csr_wdata;
         end else begin
            pass_reg_ff <= csr_wdata[3:0];
         end
      end
   end

   assign side_eff = (int'(side_reg_ff) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(side_reg_ff);

   assign req_addr    = AW'(int'(req_data.texel_y) * MAX_SIDE + int'(req_data.texel_x));
   assign center_addr = AW'(int'(y_ff) * MAX_SIDE + int'(x_ff));
   assign nx = {1'b0, x_ff} + (SW + 1)'(kx_ff) - (SW + 1)'(1);
   assign ny = {1'b0, y_ff} + (SW + 1)'(ky_ff) - (SW + 1)'(1);
   assign nbr_ok = !nx[SW] && !ny[SW] && (nx[SW-1:0] < side_eff) && (ny[SW-1:0] < side_eff);
   assign nbr_addr = AW'(int'(ny[SW-1:0]) * MAX_SIDE + int'(nx[SW-1:0]));

   always_comb begin
      raddr = req_addr;
      if (ctl.center_issue) begin
         raddr = center_addr;
      end else if (ctl.nbr_issue) begin
         raddr = nbr_addr;
      end
   end

   // write port
   always_comb begin
      waddr = center_addr;
      wdata = hold_ff;
      we_a  = 1'b0;
      we_b  = 1'b0;
      if (ctl.host_accept) begin
         waddr = req_addr;
         wdata = {req_data.covered_in, CB'(req_data.blue_in), CB'(req_data.green_in),
                  CB'(req_data.red_in)};
         if (req_data.cmd == CMD_WRITE && status.req_in_range) begin
            we_a = !bank_ff;
            we_b = bank_ff;
         end
      end else if (ctl.write_copy_rd || ctl.write_copy_hold || ctl.write_mean) begin
         if (ctl.write_copy_rd) begin
            wdata = rd_word;
         end else if (ctl.write_mean) begin
            wdata = {1'b1, CB'(quo_ff[2]), CB'(quo_ff[1]), CB'(quo_ff[0])};
         end
         we_a = bank_ff;
         we_b = !bank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we_a) begin
         mem_a[waddr] <= wdata;
      end
      rd_a_ff <= mem_a[raddr];
   end

   always_ff @(posedge clock) begin
      if (we_b) begin
         mem_b[waddr] <= wdata;
      end
      rd_b_ff <= mem_b[raddr];
   end

   assign rd_word = bank_ff ? rd_b_ff : rd_a_ff;

   // bank, passes, texel walk
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff   <= 1'b0;
         passes_ff <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
         kx_ff     <= '0;
         ky_ff     <= '0;
      end else begin
         if (ctl.load_pass) begin
            passes_ff <= pass_reg_ff;
         end else if (ctl.pass_end) begin
            passes_ff <= passes_ff - 4'd1;
            bank_ff   <= !bank_ff;
         end
         if (ctl.texel_reset) begin
            x_ff <= '0;
            y_ff <= '0;
         end else if (ctl.texel_next) begin
            if (x_ff + SW'(1) == side_eff) begin
               x_ff <= '0;
               y_ff <= y_ff + SW'(1);
            end else begin
               x_ff <= x_ff + SW'(1);
            end
         end
         if (ctl.acc_clear) begin
            kx_ff <= '0;
            ky_ff <= '0;
         end else if (ctl.acc_en) begin
            if (kx_ff == 2'd2) begin
               kx_ff <= '0;
               ky_ff <= ky_ff + 2'd1;
            end else begin
               kx_ff <= kx_ff + 2'd1;
            end
         end
      end
   end

   // gather and divide
   always_ff @(posedge clock) begin
      logic [4:0] t;
      if (ctl.center_issue) begin
         nbr_ok_ff <= 1'b0;
      end else if (ctl.nbr_issue) begin
         nbr_ok_ff <= nbr_ok;
      end
      if (ctl.acc_clear) begin
         hold_ff  <= rd_word;
         count_ff <= '0;
         for (int c = 0; c < 3; c++) begin
            acc_ff[c] <= '0;
         end
      end else if (ctl.acc_en && nbr_ok_ff && rd_word[WW-1]) begin
         count_ff <= count_ff + 4'd1;
         for (int c = 0; c < 3; c++) begin
            acc_ff[c] <= acc_ff[c] + SUMW'(rd_word[c*CB +: CB]);
         end
      end
      if (ctl.div_load) begin
         div_cnt_ff <= '0;
         for (int c = 0; c < 3; c++) begin
            quo_ff[c] <= acc_ff[c];
            rem_ff[c] <= '0;
         end
      end else if (ctl.div_step) begin
         div_cnt_ff <= div_cnt_ff + DCW'(1);
         for (int c = 0; c < 3; c++) begin
            t = {rem_ff[c], quo_ff[c][SUMW-1]};
            if (t >= {1'b0, count_ff}) begin
               rem_ff[c] <= 4'(t - {1'b0, count_ff});
               quo_ff[c] <= {quo_ff[c][SUMW-2:0], 1'b1};
            end else begin
               rem_ff[c] <= t[3:0];
               quo_ff[c] <= {quo_ff[c][SUMW-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      status.req_in_range   = (SW'(req_data.texel_x) < side_eff)
                              && (SW'(req_data.texel_y) < side_eff)
                              && (int'(req_data.texel_x) < int'(side_eff))
                              && (int'(req_data.texel_y) < int'(side_eff));
      status.passes_zero    = (passes_ff == 4'd0);
      status.side_zero      = (side_eff == '0);
      status.last_texel     = (x_ff + SW'(1) == side_eff) && (y_ff + SW'(1) == side_eff);
      status.center_covered = rd_word[WW-1];
      status.nbr_last       = (kx_ff == 2'd2) && (ky_ff == 2'd2);
      status.count_zero     = (count_ff == 4'd0);
      status.div_done       = (div_cnt_ff == DCW'(SUMW));
   end

   always_comb begin
      rsp_data = '0;
      if (ctl.reply_done) begin
         rsp_data.reply_kind = KIND_DONE;
      end else begin
         rsp_data.reply_kind  = KIND_READ;
         rsp_data.red_out     = 16'(rd_word[0 +: CB]);
         rsp_data.green_out   = 16'(rd_word[CB +: CB]);
         rsp_data.blue_out    = 16'(rd_word[2*CB +: CB]);
         rsp_data.covered_out = rd_word[WW-1];
      end
   end

endmodule
`default_nettype wire

[dv/lightmap_checker.sv]
`default_nettype none
module lightmap_checker
   import cmbd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic       busy,
   input  var  req_type    req_data,
   input  wire logic       rsp_valid,
   input  var  rsp_type    rsp_data,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata,
   output int              mismatches,
   output int              outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIDE_LIMIT = 128;
   localparam int CELLS      = SIDE_LIMIT * SIDE_LIMIT;

   logic [15:0] red_mem   [2][CELLS];
   logic [15:0] green_mem [2][CELLS];
   logic [15:0] blue_mem  [2][CELLS];
   logic        cover_mem [2][CELLS];
   int          live_bank;
   logic [7:0]  side_reg;
   logic [3:0]  pass_reg;
   rsp_type     expected_replies[$];

   function automatic int side_in_use();
      return (side_reg > SIDE_LIMIT) ? SIDE_LIMIT : int'(side_reg);
   endfunction

   // one pass: live bank read, other bank written, then swap
   function automatic void dilate_once(input int s);
      int src, dst, at, n, cnt, x, y, dx, dy, nx, ny;
      int unsigned sum_r, sum_g, sum_b;
      src = live_bank;
      dst = live_bank ^ 1;
      for (y = 0; y < s; y++) begin
         for (x = 0; x < s; x++) begin
            at = y * SIDE_LIMIT + x;
            red_mem[dst][at]   = red_mem[src][at];
            green_mem[dst][at] = green_mem[src][at];
            blue_mem[dst][at]  = blue_mem[src][at];
            cover_mem[dst][at] = cover_mem[src][at];
            if (!cover_mem[src][at]) begin
               cnt = 0;
               sum_r = 0;
               sum_g = 0;
               sum_b = 0;
               for (dy = -1; dy <= 1; dy++) begin
                  for (dx = -1; dx <= 1; dx++) begin
                     ny = y + dy;
                     nx = x + dx;
                     if (ny >= 0 && nx >= 0 && ny < s && nx < s) begin
                        n = ny * SIDE_LIMIT + nx;
                        if (cover_mem[src][n]) begin
                           sum_r += red_mem[src][n];
                           sum_g += green_mem[src][n];
                           sum_b += blue_mem[src][n];
                           cnt++;
                        end
                     end
                  end
               end
               if (cnt > 0) begin
                  red_mem[dst][at]   = 16'(sum_r / cnt);
                  green_mem[dst][at] = 16'(sum_g / cnt);
                  blue_mem[dst][at]  = 16'(sum_b / cnt);
                  cover_mem[dst][at] = 1'b1;
               end
            end
         end
      end
      live_bank = dst;
   endfunction

   function automatic void predict_request(input req_type r);
      int s, at, p;
      rsp_type reply;
      s = side_in_use();
      at = int'(r.texel_y) * SIDE_LIMIT + int'(r.texel_x);
      reply = '0;
      if (r.cmd == CMD_DILATE) begin
         for (p = 0; p < pass_reg; p++) dilate_once(s);
         reply.reply_kind = KIND_DONE;
         expected_replies = {expected_replies, reply};
      end else if (r.cmd == CMD_WRITE || r.cmd == CMD_READ) begin
         if (r.texel_x < s && r.texel_y < s) begin
            if (r.cmd == CMD_WRITE) begin
               red_mem[live_bank][at]   = r.red_in;
               green_mem[live_bank][at] = r.green_in;
               blue_mem[live_bank][at]  = r.blue_in;
               cover_mem[live_bank][at] = r.covered_in;
            end else begin
               reply.reply_kind  = KIND_READ;
               reply.red_out     = red_mem[live_bank][at];
               reply.green_out   = green_mem[live_bank][at];
               reply.blue_out    = blue_mem[live_bank][at];
               reply.covered_out = cover_mem[live_bank][at];
               expected_replies = {expected_replies, reply};
            end
         end
      end
   endfunction

   function automatic void compare_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_replies.delete();
         live_bank = 0;
         side_reg = SIDE_RESET;
         pass_reg = PASS_RESET;
         mismatches = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: unexpected reply, expected none actual %h", $time, rsp_data);
               mismatches++;
            end else begin
               want = expected_replies.pop_front();
               compare_field("reply_kind", 16'(want.reply_kind), 16'(rsp_data.reply_kind));
               compare_field("red_out", want.red_out, rsp_data.red_out);
               compare_field("green_out", want.green_out, rsp_data.green_out);
               compare_field("blue_out", want.blue_out, rsp_data.blue_out);
               compare_field("covered_out", 16'(want.covered_out),
                             16'(rsp_data.covered_out));
            end
         end
         if (start && !busy) predict_request(req_data);
         if (csr_we) begin
            if (csr_index == REG_IMAGE_SIDE) side_reg = csr_wdata;
            else pass_reg = csr_wdata[3:0];
         end
      end
      outstanding <= expected_replies.size();
   end
endmodule
`default_nettype wire

[dv/tb_coverage_masked_box_dilation_unit.sv]
`default_nettype none
module tb_coverage_masked_box_dilation_unit;
   import cmbd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIDE_LIMIT  = 128;
   localparam int CELLS       = SIDE_LIMIT * SIDE_LIMIT;
   // worst dilation here is side 5 with 15 passes
   localparam int QUIET_LIMIT = 200000;
   // command code the block leaves unused
   localparam logic [1:0] CMD_SPARE = 2'd3;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic       csr_index = REG_IMAGE_SIDE;
   logic [7:0] csr_wdata = '0;
   int         mismatches;
   int         outstanding;

   // stimulus-side view of the image: which texels hold defined data
   bit         texel_known[CELLS];
   int         written_at[$];
   int         side_now = 128;
   int         passes_now = 4;
   int         sent = 0;
   int         quiet = 0;

   coverage_masked_box_dilation_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   lightmap_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .mismatches(mismatches),
      .outstanding(outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog: run is stuck if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic int eff_side();
      return (side_now > SIDE_LIMIT) ? SIDE_LIMIT : side_now;
   endfunction

   function automatic logic [15:0] pick_chan();
      int k;
      k = $urandom_range(99);
      if (k < 10) return 16'h0000;
      if (k < 20) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic req_type make_req(input logic [1:0] cmd, input int x, input int y,
                                        input logic [15:0] r, input logic [15:0] g,
                                        input logic [15:0] b, input logic c);
      req_type q;
      q.cmd = cmd;
      q.texel_x = 7'(x);
      q.texel_y = 7'(y);
      q.red_in = r;
      q.green_in = g;
      q.blue_in = b;
      q.covered_in = c;
      return q;
   endfunction

   function automatic req_type rand_write(input int x, input int y);
      return make_req(CMD_WRITE, x, y, pick_chan(), pick_chan(), pick_chan(),
                      $urandom_range(99) < 40);
   endfunction

   // one request, with sender gaps set by how far into the run we are
   task automatic send_req(input req_type r);
      int pct, s, i;
      pct = (sent < 200) ? 34 : (sent < 400) ? 72 : 0;
      // each idle cycle is drawn on its own
      while ($urandom_range(99) < pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sent++;
      s = eff_side();
      if (r.cmd == CMD_WRITE && r.texel_x < s && r.texel_y < s) begin
         texel_known[int'(r.texel_y) * SIDE_LIMIT + int'(r.texel_x)] = 1'b1;
         written_at = {written_at, int'(r.texel_y) * SIDE_LIMIT + int'(r.texel_x)};
      end
      // passes rewrite only the in-side texels of the other bank
      if (r.cmd == CMD_DILATE && passes_now != 0)
         for (i = 0; i < CELLS; i++)
            if (i % SIDE_LIMIT >= s || i / SIDE_LIMIT >= s) texel_known[i] = 1'b0;
   endtask

   // wait until every reply is in and the block has settled
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_regs(input int side, input int passes);
      drain();
      csr_we <= 1'b1;
      csr_index <= REG_IMAGE_SIDE;
      csr_wdata <= 8'(side);
      @(posedge clock);
      csr_index <= REG_PASS_COUNT;
      csr_wdata <= {4'($urandom_range(15)), 4'(passes)};
      @(posedge clock);
      csr_we <= 1'b0;
      side_now = side;
      passes_now = passes;
   endtask

   task automatic fill_image();
      int x, y;
      for (y = 0; y < eff_side(); y++)
         for (x = 0; x < eff_side(); x++) send_req(rand_write(x, y));
   endtask

   task automatic random_req();
      int s, k, x, y, at;
      s = eff_side();
      k = $urandom_range(99);
      x = (s > 0) ? $urandom_range(s - 1) : 0;
      y = (s > 0) ? $urandom_range(s - 1) : 0;
      if (k >= 40 && k < 70 && s > 8) begin
         // large image: read back something written earlier
         at = (written_at.size() > 0) ? written_at[$urandom_range(written_at.size() - 1)]
                                      : 0;
         x = at % SIDE_LIMIT;
         y = at / SIDE_LIMIT;
      end
      if (k >= 70 && k < 80 && s < SIDE_LIMIT) begin
         // off-image write or read, ignored by the block
         x = $urandom_range(127, s);
         y = $urandom_range(127);
         if ($urandom_range(1)) begin
            k = x;
            x = y;
            y = k;
         end
         if ($urandom_range(1)) send_req(rand_write(x, y));
         else send_req(make_req(CMD_READ, x, y, pick_chan(), pick_chan(), pick_chan(),
                                1'($urandom)));
      end else if (k >= 80 && k < 86) begin
         send_req(make_req(CMD_SPARE, $urandom_range(127), $urandom_range(127), pick_chan(),
                           pick_chan(), pick_chan(), 1'($urandom)));
      end else if (k >= 86 && (s <= 8 || passes_now == 0)) begin
         send_req(make_req(CMD_DILATE, $urandom_range(127), $urandom_range(127),
                           pick_chan(), pick_chan(), pick_chan(), 1'($urandom)));
      end else if (k >= 40 && s > 0 && x < s && y < s
                   && texel_known[y * SIDE_LIMIT + x]) begin
         send_req(make_req(CMD_READ, x, y, pick_chan(), pick_chan(), pick_chan(),
                           1'($urandom)));
      end else if (s > 0) begin
         send_req(rand_write(x, y));
      end else begin
         send_req(rand_write($urandom_range(127), $urandom_range(127)));
      end
   endtask

   initial begin
      int sides[10]  = '{4, 1, 8, 0, 255, 128, 2, 5, 6, 3};
      int passes[10] = '{1, 15, 2, 7, 0, 0, 3, 15, 5, 1};
      int ph, n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, field extremes, unused command
      send_req(make_req(CMD_WRITE, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
      send_req(make_req(CMD_WRITE, 127, 127, 16'h0000, 16'h0000, 16'h0000, 1'b0));
      send_req(make_req(CMD_WRITE, 127, 0, 16'h5555, 16'hAAAA, 16'h5555, 1'b1));
      send_req(make_req(CMD_READ, 0, 0, '0, '0, '0, 1'b0));
      send_req(make_req(CMD_READ, 127, 127, '0, '0, '0, 1'b0));
      send_req(make_req(CMD_SPARE, 127, 127, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
      send_req(make_req(CMD_READ, 127, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));

      // one pass on a 3x3 image, centre texel left uncovered
      set_regs(3, 1);
      fill_image();
      send_req(make_req(CMD_WRITE, 1, 1, 16'h1234, 16'h5678, 16'h9ABC, 1'b0));
      send_req(make_req(CMD_DILATE, 0, 0, '0, '0, '0, 1'b0));
      send_req(make_req(CMD_READ, 1, 1, '0, '0, '0, 1'b0));
      send_req(make_req(CMD_READ, 0, 0, '0, '0, '0, 1'b0));
      // addresses off the image are dropped
      send_req(make_req(CMD_WRITE, 5, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
      send_req(make_req(CMD_READ, 1, 5, '0, '0, '0, 1'b0));

      // empty image still replies to a dilate
      set_regs(0, 15);
      send_req(make_req(CMD_DILATE, 0, 0, '0, '0, '0, 1'b0));
      send_req(make_req(CMD_READ, 0, 0, '0, '0, '0, 1'b0));

      // oversized side behaves as the full store, zero passes still reply
      set_regs(255, 0);
      send_req(make_req(CMD_WRITE, 127, 127, 16'hA5A5, 16'h5A5A, 16'hFFFF, 1'b1));
      send_req(make_req(CMD_READ, 127, 127, '0, '0, '0, 1'b0));
      send_req(make_req(CMD_DILATE, 0, 0, '0, '0, '0, 1'b0));
      send_req(make_req(CMD_READ, 127, 127, '0, '0, '0, 1'b0));

      // random phases, each with its own register settings
      for (ph = 0; ph < 10; ph++) begin
         set_regs(sides[ph], passes[ph]);
         if (sides[ph] <= 8) fill_image();
         for (n = 0; n < 40; n++) random_req();
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
`default_nettype wire
